// ----- rtl/tcpu_pkg.sv -----
// Package for the tiny 8-bit processor core: function codes, opcodes,
// instruction classes, sizes and the controller state type. No dependencies.
package tcpu_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned RegCount = 16;
  localparam int unsigned DataW    = 8;

  typedef enum logic [2:0] {
    FUNC_LD_INSTR = 3'd0,
    FUNC_LD_DATA  = 3'd1,
    FUNC_LD_REG   = 3'd2,
    FUNC_EXEC     = 3'd3,
    FUNC_RD_DATA  = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_INC  = 4'd3,
    OP_AND  = 4'd4,  OP_OR   = 4'd5,  OP_XOR  = 4'd6,  OP_NOT  = 4'd7,
    OP_SLLI = 4'd8,  OP_SRLI = 4'd9,  OP_LI   = 4'd10, OP_LD   = 4'd11,
    OP_ST   = 4'd12, OP_JMP  = 4'd13, OP_BEQZ = 4'd14, OP_HLT  = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    CLS_ARITH = 3'd0,
    CLS_LOGIC = 3'd1,
    CLS_SHIFT = 3'd2,
    CLS_MEM   = 3'd3,
    CLS_LIMM  = 3'd4,
    CLS_CTRL  = 3'd5,
    CLS_HALT  = 3'd6
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH0,
    ST_FETCH1,
    ST_EXEC,
    ST_MEM,
    ST_DONE
  } state_e;

  function automatic cls_e op_class(input logic [3:0] op);
    cls_e c;
    c = CLS_ARITH;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_INC:   c = CLS_ARITH;
      OP_AND, OP_OR, OP_XOR, OP_NOT:    c = CLS_LOGIC;
      OP_SLLI, OP_SRLI:                 c = CLS_SHIFT;
      OP_LI:                            c = CLS_LIMM;
      OP_LD, OP_ST:                     c = CLS_MEM;
      OP_JMP, OP_BEQZ:                  c = CLS_CTRL;
      default:                          c = CLS_HALT;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tiny_8bit_cpu_core.sv -----
// Top level of the tiny 8-bit processor core: controller, register file,
// instruction and data RAMs. Depends on tcpu_pkg, tcpu_ram and tcpu_alu.
//
// Usage: drive func_i, address_i and write_value_i with start high while
// busy is low; that edge takes the request. Exactly one result follows,
// shown for one cycle with done_o high; the receiver cannot stall it.
// Loads, reads and unknown functions pass through the MEM and DONE states;
// done_o is registered from DONE. An execute request first takes two
// instruction RAM reads on one port, then a register and operate step, a
// data RAM access step, a step to capture load data and the output
// register. Execute while halted behaves as a load.
// busy is high from the request up to the done_o cycle and low in it, so
// the next request can be taken at the edge that ends the done_o cycle.
// Reset clears the register file, program counter and halt flag; both RAMs
// hold undefined data until written.
module tiny_8bit_cpu_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func_i,
  input  logic [7:0]        address_i,
  input  logic signed [7:0] write_value_i,
  output logic              done_o,
  output logic signed [7:0] read_value_o,
  output logic [7:0]        program_counter_o,
  output logic              halted_o,
  output logic              executed_o,
  output logic [2:0]        instr_class_o
);

  localparam int unsigned AW = $clog2(tcpu_pkg::MemDepth);

  tcpu_pkg::state_e state_q, state_d;
  logic [2:0] func_q;
  logic [7:0] addr_q, wval_q, b0_q, pc_q, pc_d;
  logic       halt_q, halt_d;
  logic [7:0] regs_q [tcpu_pkg::RegCount];
  logic [7:0] rv_q, rv_d;
  logic       exe_q, exe_d;
  logic [2:0] cls_q, cls_d;

  logic          im_we, dm_we;
  logic [AW-1:0] im_addr, dm_addr;
  logic [7:0]    im_wdata, dm_wdata, im_rdata, dm_rdata;

  logic [3:0] op, rd, ra, rb;
  logic [7:0] x, y, dv, alu_res, eff;
  logic [7:0] b1_q;

  assign op  = b0_q[7:4];
  assign rd  = b0_q[3:0];
  assign ra  = b1_q[7:4];
  assign rb  = b1_q[3:0];
  assign x   = regs_q[ra];
  assign y   = regs_q[rb];
  assign dv  = regs_q[rd];
  assign eff = x + {{4{rb[3]}}, rb};

  tcpu_ram #(.Width(8), .Depth(tcpu_pkg::MemDepth)) u_imem (
    .clk_i(clk_i), .we_i(im_we), .addr_i(im_addr), .wdata_i(im_wdata),
    .rdata_o(im_rdata)
  );

  tcpu_ram #(.Width(8), .Depth(tcpu_pkg::MemDepth)) u_dmem (
    .clk_i(clk_i), .we_i(dm_we), .addr_i(dm_addr), .wdata_i(dm_wdata),
    .rdata_o(dm_rdata)
  );

  tcpu_alu u_alu (
    .op_i(op), .x_i(x), .y_i(y), .d_i(dv), .imm_i(b1_q), .res_o(alu_res)
  );

  assign busy = (state_q != tcpu_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcpu_pkg::ST_IDLE:
        if (start) begin
          if (func_i == tcpu_pkg::FUNC_EXEC && !halt_q) state_d = tcpu_pkg::ST_FETCH0;
          else state_d = tcpu_pkg::ST_MEM;
        end
      tcpu_pkg::ST_FETCH0: state_d = tcpu_pkg::ST_FETCH1;
      tcpu_pkg::ST_FETCH1: state_d = tcpu_pkg::ST_EXEC;
      tcpu_pkg::ST_EXEC:   state_d = tcpu_pkg::ST_MEM;
      tcpu_pkg::ST_MEM:    state_d = tcpu_pkg::ST_DONE;
      tcpu_pkg::ST_DONE:   state_d = tcpu_pkg::ST_IDLE;
      default:             state_d = tcpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    im_we    = 1'b0;
    dm_we    = 1'b0;
    im_addr  = addr_q[AW-1:0];
    dm_addr  = addr_q[AW-1:0];
    im_wdata = wval_q;
    dm_wdata = wval_q;
    pc_d     = pc_q;
    halt_d   = halt_q;
    rv_d     = rv_q;
    exe_d    = exe_q;
    cls_d    = cls_q;
    case (state_q)
      tcpu_pkg::ST_IDLE: begin
        rv_d  = '0;
        exe_d = 1'b0;
        cls_d = tcpu_pkg::CLS_ARITH;
        im_addr = pc_q[AW-1:0];
      end
      tcpu_pkg::ST_FETCH0: im_addr = AW'(pc_q + 8'd1);
      tcpu_pkg::ST_EXEC: begin
        exe_d = 1'b1;
        cls_d = tcpu_pkg::op_class(op);
        pc_d  = pc_q + 8'd2;
        dm_addr  = eff[AW-1:0];
        dm_wdata = dv;
        case (op)
          tcpu_pkg::OP_ST:   dm_we = 1'b1;
          tcpu_pkg::OP_JMP:  pc_d = pc_q + 8'd2 + {rd[2:0], ra, 1'b0};
          tcpu_pkg::OP_BEQZ: if (dv == 8'd0) pc_d = pc_q + 8'd2 + {b1_q[6:0], 1'b0};
          tcpu_pkg::OP_HLT:  halt_d = 1'b1;
          tcpu_pkg::OP_LD:   ;
          default:           rv_d = alu_res;
        endcase
      end
      tcpu_pkg::ST_MEM: begin
        if (!exe_q) begin
          case (func_q)
            tcpu_pkg::FUNC_LD_INSTR: im_we = 1'b1;
            tcpu_pkg::FUNC_LD_DATA:  dm_we = 1'b1;
            default: ;
          endcase
        end else begin
          dm_addr = eff[AW-1:0];
        end
      end
      tcpu_pkg::ST_DONE: begin
        if (!exe_q && func_q == tcpu_pkg::FUNC_RD_DATA) rv_d = dm_rdata;
        if (exe_q && op == tcpu_pkg::OP_LD) rv_d = dm_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpu_pkg::ST_IDLE;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      exe_q   <= 1'b0;
      for (int i = 0; i < tcpu_pkg::RegCount; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      exe_q   <= exe_d;
      if (state_q == tcpu_pkg::ST_MEM && !exe_q && func_q == tcpu_pkg::FUNC_LD_REG) begin
        regs_q[addr_q[3:0]] <= wval_q;
      end
      if (state_q == tcpu_pkg::ST_EXEC && op != tcpu_pkg::OP_LD && op != tcpu_pkg::OP_ST &&
          op != tcpu_pkg::OP_JMP && op != tcpu_pkg::OP_BEQZ && op != tcpu_pkg::OP_HLT) begin
        regs_q[rd] <= alu_res;
      end
      if (state_q == tcpu_pkg::ST_DONE && exe_q && op == tcpu_pkg::OP_LD) begin
        regs_q[rd] <= dm_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q  <= rv_d;
    cls_q <= cls_d;
    if (state_q == tcpu_pkg::ST_IDLE && start) begin
      func_q <= func_i;
      addr_q <= address_i;
      wval_q <= write_value_i;
    end
    if (state_q == tcpu_pkg::ST_FETCH0) b0_q <= im_rdata;
    if (state_q == tcpu_pkg::ST_FETCH1) b1_q <= im_rdata;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= (state_q == tcpu_pkg::ST_DONE);
  end

  // Result regs settle in DONE; present them the following IDLE cycle.
  assign done_o            = done_q;
  assign read_value_o      = rv_q;
  assign program_counter_o = pc_q;
  assign halted_o          = halt_q;
  assign executed_o        = exe_q;
  assign instr_class_o     = cls_q;

endmodule

// ----- rtl/tcpu_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module tcpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- rtl/tcpu_alu.sv -----
// Register-to-register and immediate operations of the tiny processor core.
// Depends on tcpu_pkg.
module tcpu_alu (
  input  logic [3:0] op_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] d_i,
  input  logic [7:0] imm_i,
  output logic [7:0] res_o
);

  logic [15:0] prod;

  assign prod = x_i * y_i;

  always_comb begin
    res_o = '0;
    case (op_i)
      tcpu_pkg::OP_ADD:  res_o = x_i + y_i;
      tcpu_pkg::OP_SUB:  res_o = x_i - y_i;
      tcpu_pkg::OP_MUL:  res_o = prod[7:0];
      tcpu_pkg::OP_INC:  res_o = d_i + 8'd1;
      tcpu_pkg::OP_AND:  res_o = x_i & y_i;
      tcpu_pkg::OP_OR:   res_o = x_i | y_i;
      tcpu_pkg::OP_XOR:  res_o = x_i ^ y_i;
      tcpu_pkg::OP_NOT:  res_o = ~x_i;
      tcpu_pkg::OP_SLLI: res_o = imm_i[3] ? 8'd0 : (x_i << imm_i[2:0]);
      tcpu_pkg::OP_SRLI: res_o = imm_i[3] ? 8'd0 : (x_i >> imm_i[2:0]);
      tcpu_pkg::OP_LI:   res_o = imm_i;
      default:           res_o = '0;
    endcase
  end

endmodule
